@@ rtl/core/booth_signed_multiplier_top_macros.svh @@
// Assertion macros used by the Booth multiplier controller.
`ifndef BOOTH_SIGNED_MULTIPLIER_TOP_MACROS_SVH
`define BOOTH_SIGNED_MULTIPLIER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsm assertion failed");

`endif

@@ rtl/core/bsm_pkg.sv @@
// Package with shared constants and types of the Booth multiplier.
`default_nettype none

package bsm_pkg;

  // Default operand width in bits.
  localparam int BSM_WIDTH = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // Load operands and clear the accumulator.
    logic step;     // Perform one Booth add/subtract and shift.
    logic capture;  // Write the stepped values into the product register.
  } bsm_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/bsm_if.sv @@
// Valid/ready channel interfaces for operands and products.
`default_nettype none

interface bsm_in_if
  import bsm_pkg::*;
#(
  parameter int WIDTH = BSM_WIDTH
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] multiplicand;
  logic signed [WIDTH-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bsm_out_if
  import bsm_pkg::*;
#(
  parameter int WIDTH = BSM_WIDTH
) ();
  logic                      valid;
  logic                      ready;
  logic signed [2*WIDTH-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bsm_ctrl.sv @@
// Controller state machine that sequences the Booth steps and the output handshake.
`default_nettype none

`include "booth_signed_multiplier_top_macros.svh"

module bsm_ctrl
  import bsm_pkg::*;
#(
  parameter int WIDTH = BSM_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bsm_cmd_t cmd
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The product register may be written when empty or drained this cycle.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r != CNT_LAST) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (out_free) begin
          // The last step writes the product directly.
          cmd.step      = 1'b1;
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `BSM_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.capture, !out_valid_r || out_ready)
  `BSM_ASSERT_NEXT(a_capture_valid, clk, rst_n, cmd.capture, out_valid_r)
  `BSM_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_r && !out_ready, out_valid_r)
  `BSM_ASSERT_NEXT(a_count_advance, clk, rst_n,
                   state_r == ST_RUN && cnt_r != CNT_LAST,
                   state_r == ST_RUN && cnt_r == $past(cnt_r) + 1'b1)

endmodule

`default_nettype wire

@@ rtl/core/bsm_datapath.sv @@
// Booth radix-2 datapath: accumulator, multiplier shift register and product register.
`default_nettype none

module bsm_datapath
  import bsm_pkg::*;
#(
  parameter int WIDTH = BSM_WIDTH
) (
  input  logic                      clk,
  input  bsm_cmd_t                  cmd,
  input  logic signed [WIDTH-1:0]   in_multiplicand,
  input  logic signed [WIDTH-1:0]   in_multiplier,
  output logic signed [2*WIDTH-1:0] out_product
);

  // Booth recoding of {low multiplier bit, prior bit}.
  localparam logic [1:0] BOOTH_ADD = 2'b01;
  localparam logic [1:0] BOOTH_SUB = 2'b10;

  // The accumulator carries one guard bit so the most negative operand cannot wrap.
  logic [WIDTH:0]     acc_r, acc_nxt;
  logic [WIDTH-1:0]   q_r, q_nxt;
  logic               q1_r, q1_nxt;
  logic [WIDTH-1:0]   mcand_r, mcand_nxt;
  logic [2*WIDTH-1:0] prod_r;
  logic [WIDTH:0]     mcand_ext;
  logic [WIDTH:0]     sum;
  logic [WIDTH:0]     acc_step;
  logic [WIDTH-1:0]   q_step;

  always_comb begin
    mcand_ext = {mcand_r[WIDTH-1], mcand_r};
    case ({q_r[0], q1_r})
      BOOTH_ADD: sum = acc_r + mcand_ext;
      BOOTH_SUB: sum = acc_r - mcand_ext;
      default:   sum = acc_r;
    endcase
    acc_step = {sum[WIDTH], sum[WIDTH:1]};
    q_step   = {sum[0], q_r[WIDTH-1:1]};

    acc_nxt   = acc_r;
    q_nxt     = q_r;
    q1_nxt    = q1_r;
    mcand_nxt = mcand_r;
    if (cmd.load) begin
      acc_nxt   = '0;
      q_nxt     = in_multiplier;
      q1_nxt    = 1'b0;
      mcand_nxt = in_multiplicand;
    end else if (cmd.step) begin
      acc_nxt = acc_step;
      q_nxt   = q_step;
      q1_nxt  = q_r[0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    q1_r    <= q1_nxt;
    mcand_r <= mcand_nxt;
    if (cmd.capture) begin
      prod_r <= {acc_step[WIDTH-1:0], q_step};
    end
  end

  assign out_product = prod_r;

endmodule

`default_nettype wire

@@ rtl/core/booth_signed_multiplier_top.sv @@
// Top level of the sequential radix-2 Booth signed multiplier.
//
// Usage: the operand channel in_ch transfers a signed multiplicand and a
// signed multiplier of WIDTH bits each; the result channel out_ch transfers
// the full signed product of 2*WIDTH bits, which never overflows.
// A transfer takes place on a rising clock edge with valid and ready high.
// Each operand pair yields exactly one product, in order.
// After the operand transfer the controller runs WIDTH Booth steps, one per
// cycle unless a stalled out_ch holds the last step, on a single add/subtract
// unit; the last step writes the output register, which raises out_ch.valid.
// A new operand pair is taken only once the step loop is back in idle, after
// the previous product has been written to the output register.
// in_ch.ready is high whenever the step loop is free, even while an earlier
// product still waits in the output register.
// Stall: if out_ch is stalled when the next product is due, the controller
// holds before its last step until the waiting product is taken; nothing is
// lost or overwritten.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_ch.valid; no clearing pass is needed.
`default_nettype none

module booth_signed_multiplier_top
  import bsm_pkg::*;
#(
  parameter int WIDTH = BSM_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  bsm_in_if.sink    in_ch,
  bsm_out_if.source out_ch
);

  bsm_cmd_t cmd;

  // Controller: sequences the load, the Booth steps and the output handshake.
  bsm_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: accumulator with guard bit, shift register and product register.
  bsm_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .in_multiplicand (in_ch.multiplicand),
    .in_multiplier   (in_ch.multiplier),
    .out_product     (out_ch.product)
  );

endmodule

`default_nettype wire
